### design/assert_macros.svh
// assertion helpers used by the checker file
// they expect signals named clk and arst_n in the scope of use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define LJE_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define LJE_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

### design/lje_pkg.sv
// ----------------------------------------------------------------------------
// lje_pkg
// Shared widths, codes, control types and a helper function of the
// Lennard-Jones pair energy pipeline.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package lje_pkg;

	localparam int COORD_BITS = 32;
	localparam int DIFF_W     = COORD_BITS + 1;
	localparam int SQ_W       = 2 * DIFF_W;
	localparam int R_W        = SQ_W + 2;
	localparam int P_W        = $clog2(R_W);
	localparam int M_W        = 32;
	localparam int DIV_BITS   = 4;
	localparam int DIV_STAGES = M_W / DIV_BITS;
	localparam int HALF_W     = 32;
	localparam int COEF_W     = 64;
	localparam int PROD_W     = 2 * COEF_W;
	localparam int TERM_W     = 126;
	localparam int SH_W       = 9;
	localparam int E_W        = 64;
	localparam int CFG_IDX_W  = 1;

	localparam logic [1:0] STAT_OK    = 2'd0;
	localparam logic [1:0] STAT_SAT   = 2'd1;
	localparam logic [1:0] STAT_COINC = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_REPULSIVE  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ATTRACTIVE = 1'd1;

	localparam logic [E_W-1:0] ENERGY_MAX = {1'b0, {(E_W-1){1'b1}}};
	localparam logic [E_W-1:0] ENERGY_MIN = {1'b1, {(E_W-1){1'b0}}};
	localparam logic [TERM_W-1:0] TERM_CAP = {TERM_W{1'b1}};

	typedef struct packed {
		logic vld;
		logic coinc;
	} ctl_t;

	typedef struct packed {
		logic [M_W-1:0] rem;
		logic [M_W-1:0] quo;
	} div_t;

	// DIV_BITS restoring steps; the dividend bits below the top are all ones
	function automatic div_t div_iter(input div_t cur, input logic [M_W-1:0] m);
		div_t         r;
		logic [M_W:0] t;
		r = cur;
		for (int i = 0; i < DIV_BITS; i++) begin
			t = {r.rem, 1'b1};
			if (t >= {1'b0, m}) begin
				r.rem = M_W'(t - {1'b0, m});
				r.quo = {r.quo[M_W-2:0], 1'b1};
			end else begin
				r.rem = t[M_W-1:0];
				r.quo = {r.quo[M_W-2:0], 1'b0};
			end
		end
		return r;
	endfunction

endpackage

`default_nettype wire

### design/lje_if.sv
// ----------------------------------------------------------------------------
// lje_in_if / lje_out_if
// Valid/ready channels for atom pair requests and energy results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface lje_in_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] first_x;
	logic signed [31:0] first_y;
	logic signed [31:0] first_z;
	logic signed [31:0] second_x;
	logic signed [31:0] second_y;
	logic signed [31:0] second_z;

	modport source (output valid, first_x, first_y, first_z, second_x, second_y, second_z,
		input ready);
	modport sink (input valid, first_x, first_y, first_z, second_x, second_y, second_z,
		output ready);
endinterface

interface lje_out_if;
	logic               valid;
	logic               ready;
	logic signed [63:0] pair_energy;
	logic [1:0]         status;

	modport source (output valid, pair_energy, status, input ready);
	modport sink (input valid, pair_energy, status, output ready);
endinterface

`default_nettype wire

### design/lennard_jones_energy_ab_core.sv
// throughput: one request per cycle while no result is stalled; the
// reciprocal is an 8-stage divider of 4 quotient bits per stage, so no
// unit is shared between requests
// a stalled result holds the whole pipeline in place, nothing is dropped
// reset clears all valid bits and both coefficients to zero
`timescale 1ns / 1ps
`default_nettype none

// ----------------------------------------------------------------------------
// lennard_jones_energy_ab_core
// Lennard-Jones 12-6 pair energy A/r^12 - B/r^6 of two atoms, Q32.32 out.
// ----------------------------------------------------------------------------
module lennard_jones_energy_ab_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_wr_en,
	input  logic [lje_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [lje_pkg::COEF_W-1:0]    cfg_data,
	lje_in_if.sink                        in_ch,
	lje_out_if.source                     out_ch
);
	import lje_pkg::*;

	logic              en;
	logic [COEF_W-1:0] coef_a_q, coef_b_q;
	ctl_t              dist_ctl, recip_ctl;
	logic [M_W-1:0]    dist_m;
	logic [P_W-1:0]    dist_p, recip_p;
	logic [COEF_W-1:0] recip_s, recip_u;
	logic              term_vld;
	logic [E_W-1:0]    term_energy;
	logic [1:0]        term_status;

	// the pipeline moves unless a finished result is waiting
	assign en          = !(term_vld && !out_ch.ready);
	assign in_ch.ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_a_q <= '0;
			coef_b_q <= '0;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_REPULSIVE:  coef_a_q <= cfg_data;
				REG_ATTRACTIVE: coef_b_q <= cfg_data;
				default: ;
			endcase
		end
	end

	lje_dist u_dist (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_vld   (in_ch.valid),
		.first_x  (in_ch.first_x),
		.first_y  (in_ch.first_y),
		.first_z  (in_ch.first_z),
		.second_x (in_ch.second_x),
		.second_y (in_ch.second_y),
		.second_z (in_ch.second_z),
		.ctl_o    (dist_ctl),
		.m_o      (dist_m),
		.p_o      (dist_p)
	);

	lje_recip u_recip (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.ctl_i  (dist_ctl),
		.m_i    (dist_m),
		.p_i    (dist_p),
		.ctl_o  (recip_ctl),
		.s_o    (recip_s),
		.u_o    (recip_u),
		.p_o    (recip_p)
	);

	lje_term u_term (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.ctl_i    (recip_ctl),
		.s_i      (recip_s),
		.u_i      (recip_u),
		.p_i      (recip_p),
		.coef_a   (coef_a_q),
		.coef_b   (coef_b_q),
		.vld_o    (term_vld),
		.energy_o (term_energy),
		.status_o (term_status)
	);

	assign out_ch.valid       = term_vld;
	assign out_ch.pair_energy = term_energy;
	assign out_ch.status      = term_status;

endmodule

`default_nettype wire

### design/lje_dist.sv
// ----------------------------------------------------------------------------
// lje_dist
// Difference vector, exact squared distance, leading-one search and
// 32-bit normalized mantissa of r^2 (five stages).
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lje_dist (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      en,
	input  logic                      in_vld,
	input  logic signed [31:0]        first_x,
	input  logic signed [31:0]        first_y,
	input  logic signed [31:0]        first_z,
	input  logic signed [31:0]        second_x,
	input  logic signed [31:0]        second_y,
	input  logic signed [31:0]        second_z,
	output lje_pkg::ctl_t             ctl_o,
	output logic [lje_pkg::M_W-1:0]   m_o,
	output logic [lje_pkg::P_W-1:0]   p_o
);
	import lje_pkg::*;

	logic signed [DIFF_W-1:0] dfx, dfy, dfz;
	logic [DIFF_W-1:0] dx_s1, dy_s1, dz_s1;
	logic [SQ_W-1:0]   sx_s2, sy_s2, sz_s2;
	logic [R_W-1:0]    r2_s3, r2_s4;
	logic [P_W-1:0]    p_c, p_s4, p_s5;
	logic [R_W-1:0]    norm_c;
	logic [M_W-1:0]    m_s5;
	logic              vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;
	logic              coinc_s4, coinc_s5;

	assign dfx = {second_x[COORD_BITS-1], second_x[COORD_BITS-1:0]}
		- {first_x[COORD_BITS-1], first_x[COORD_BITS-1:0]};
	assign dfy = {second_y[COORD_BITS-1], second_y[COORD_BITS-1:0]}
		- {first_y[COORD_BITS-1], first_y[COORD_BITS-1:0]};
	assign dfz = {second_z[COORD_BITS-1], second_z[COORD_BITS-1:0]}
		- {first_z[COORD_BITS-1], first_z[COORD_BITS-1:0]};

	// leading one of r^2
	always_comb begin
		p_c = '0;
		for (int i = 0; i < R_W; i++) begin
			if (r2_s3[i]) p_c = P_W'(i);
		end
	end

	assign norm_c = r2_s4 << (P_W'(R_W - 1) - p_s4);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dx_s1    <= dfx[DIFF_W-1] ? DIFF_W'(-dfx) : DIFF_W'(dfx);
			dy_s1    <= dfy[DIFF_W-1] ? DIFF_W'(-dfy) : DIFF_W'(dfy);
			dz_s1    <= dfz[DIFF_W-1] ? DIFF_W'(-dfz) : DIFF_W'(dfz);
			sx_s2    <= dx_s1 * dx_s1;
			sy_s2    <= dy_s1 * dy_s1;
			sz_s2    <= dz_s1 * dz_s1;
			r2_s3    <= R_W'(sx_s2) + R_W'(sy_s2) + R_W'(sz_s2);
			r2_s4    <= r2_s3;
			p_s4     <= p_c;
			coinc_s4 <= (r2_s3 == '0);
			m_s5     <= norm_c[R_W-1 -: M_W];
			p_s5     <= p_s4;
			coinc_s5 <= coinc_s4;
		end
	end

	assign ctl_o = '{vld: vld_s5, coinc: coinc_s5};
	assign m_o   = m_s5;
	assign p_o   = p_s5;

endmodule

`default_nettype wire

### design/lje_recip.sv
// ----------------------------------------------------------------------------
// lje_recip
// Pipelined reciprocal of the mantissa, then r^-6 and r^-12 mantissas
// from split 32-bit products.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lje_recip (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        en,
	input  lje_pkg::ctl_t               ctl_i,
	input  logic [lje_pkg::M_W-1:0]     m_i,
	input  logic [lje_pkg::P_W-1:0]     p_i,
	output lje_pkg::ctl_t               ctl_o,
	output logic [lje_pkg::COEF_W-1:0]  s_o,
	output logic [lje_pkg::COEF_W-1:0]  u_o,
	output logic [lje_pkg::P_W-1:0]     p_o
);
	import lje_pkg::*;

	// divider stages, one array slot per stage
	div_t           dv_s6_13  [DIV_STAGES];
	logic [M_W-1:0] m_s6_13   [DIV_STAGES];
	logic [P_W-1:0] p_s6_13   [DIV_STAGES];
	ctl_t           ctl_s6_13 [DIV_STAGES];
	div_t           dv_start;

	logic [2*M_W-1:0]    qq_s14;
	logic [M_W-1:0]      q_s14;
	logic [2*M_W-1:0]    ph_s15, pl_s15;
	logic [COEF_W-1:0]   s_s16, s_s17, s_s18;
	logic [2*HALF_W-1:0] hh_s17, hl_s17, lh_s17, ll_s17;
	logic [COEF_W-1:0]   u_s18;
	logic [PROD_W-1:0]   sq_c;
	logic [P_W-1:0]      p_s14, p_s15, p_s16, p_s17, p_s18;
	ctl_t                ctl_s14, ctl_s15, ctl_s16, ctl_s17, ctl_s18;

	// remainder after the upper dividend bits, all ones and below the divisor
	assign dv_start = '{rem: {1'b0, {(M_W-1){1'b1}}}, quo: '0};

	for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				ctl_s6_13[g] <= '0;
			end else if (en) begin
				ctl_s6_13[g] <= (g == 0) ? ctl_i : ctl_s6_13[(g == 0) ? 0 : g-1];
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				if (g == 0) begin
					dv_s6_13[g]        <= div_iter(dv_start, m_i);
					m_s6_13[g]         <= m_i;
					p_s6_13[g]         <= p_i;
				end else begin
					dv_s6_13[g]        <= div_iter(dv_s6_13[(g == 0) ? 0 : g-1],
						m_s6_13[(g == 0) ? 0 : g-1]);
					m_s6_13[g]         <= m_s6_13[(g == 0) ? 0 : g-1];
					p_s6_13[g]         <= p_s6_13[(g == 0) ? 0 : g-1];
				end
			end
		end
	end

	assign sq_c = {hh_s17, {COEF_W{1'b0}}} + {{HALF_W{1'b0}}, hl_s17, {HALF_W{1'b0}}}
		+ {{HALF_W{1'b0}}, lh_s17, {HALF_W{1'b0}}} + {{COEF_W{1'b0}}, ll_s17};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s14 <= '0;
			ctl_s15 <= '0;
			ctl_s16 <= '0;
			ctl_s17 <= '0;
			ctl_s18 <= '0;
		end else if (en) begin
			ctl_s14 <= ctl_s6_13[DIV_STAGES-1];
			ctl_s15 <= ctl_s14;
			ctl_s16 <= ctl_s15;
			ctl_s17 <= ctl_s16;
			ctl_s18 <= ctl_s17;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			q_s14         <= dv_s6_13[DIV_STAGES-1].quo;
			qq_s14        <= dv_s6_13[DIV_STAGES-1].quo * dv_s6_13[DIV_STAGES-1].quo;
			p_s14         <= p_s6_13[DIV_STAGES-1];
			// q^3 split over the halves of q^2
			ph_s15        <= qq_s14[2*M_W-1:M_W] * q_s14;
			pl_s15        <= qq_s14[M_W-1:0] * q_s14;
			p_s15         <= p_s14;
			s_s16         <= ph_s15 + COEF_W'(pl_s15[2*M_W-1:M_W]);
			p_s16         <= p_s15;
			hh_s17        <= s_s16[COEF_W-1:HALF_W] * s_s16[COEF_W-1:HALF_W];
			hl_s17        <= s_s16[COEF_W-1:HALF_W] * s_s16[HALF_W-1:0];
			lh_s17        <= s_s16[HALF_W-1:0] * s_s16[COEF_W-1:HALF_W];
			ll_s17        <= s_s16[HALF_W-1:0] * s_s16[HALF_W-1:0];
			s_s17         <= s_s16;
			p_s17         <= p_s16;
			u_s18         <= sq_c[PROD_W-1:COEF_W];
			s_s18         <= s_s17;
			p_s18         <= p_s17;
		end
	end

	assign ctl_o = ctl_s18;
	assign s_o   = s_s18;
	assign u_o   = u_s18;
	assign p_o   = p_s18;

endmodule

`default_nettype wire

### design/lje_term.sv
// ----------------------------------------------------------------------------
// lje_term
// Coefficient products, power-of-two scaling with clamping, difference
// of the two terms and signed 64-bit saturation.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lje_term (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        en,
	input  lje_pkg::ctl_t               ctl_i,
	input  logic [lje_pkg::COEF_W-1:0]  s_i,
	input  logic [lje_pkg::COEF_W-1:0]  u_i,
	input  logic [lje_pkg::P_W-1:0]     p_i,
	input  logic [lje_pkg::COEF_W-1:0]  coef_a,
	input  logic [lje_pkg::COEF_W-1:0]  coef_b,
	output logic                        vld_o,
	output logic [lje_pkg::E_W-1:0]     energy_o,
	output logic [1:0]                  status_o
);
	import lje_pkg::*;

	logic [2*HALF_W-1:0] ahh_s19, ahl_s19, alh_s19, all_s19;
	logic [2*HALF_W-1:0] bhh_s19, bhl_s19, blh_s19, bll_s19;
	logic [P_W-1:0]      p_s19;
	ctl_t                ctl_s19, ctl_s20, ctl_s21, ctl_s22;
	logic [PROD_W-1:0]   pa_s20, pb_s20;
	logic [SH_W-1:0]     l12_s20, r12_s20, sh12_s20, l6_s20, r6_s20, sh6_s20;
	logic                k12pos_s20, k6pos_s20, p0_s20;
	logic [SH_W-1:0]     p6_c, p3_c;
	logic [PROD_W-1:0]   v12_c, v6_c;
	logic                sat12_c, sat6_c;
	logic [TERM_W-1:0]   t12_s21, t6_s21;
	logic                sat_s21, sat_s22;
	logic signed [TERM_W:0] diff_c, diff_s22;
	logic                vld_s23;
	logic [E_W-1:0]      energy_s23;
	logic [1:0]          status_s23;

	function automatic logic [PROD_W-1:0] join_prod(input logic [2*HALF_W-1:0] hh, hl, lh, ll);
		return {hh, {COEF_W{1'b0}}} + {{HALF_W{1'b0}}, hl, {HALF_W{1'b0}}}
			+ {{HALF_W{1'b0}}, lh, {HALF_W{1'b0}}} + {{COEF_W{1'b0}}, ll};
	endfunction

	assign p6_c = SH_W'(p_s19) * SH_W'(6);
	assign p3_c = SH_W'(p_s19) * SH_W'(3);

	// scale by 2^(128-6p) and 2^(64-3p); clamp where the term reaches 2^126
	assign v12_c   = k12pos_s20 ? (pa_s20 << l12_s20) : (pa_s20 >> r12_s20);
	assign v6_c    = k6pos_s20 ? (pb_s20 << l6_s20) : (pb_s20 >> r6_s20);
	assign sat12_c = (pa_s20 != '0) && (p0_s20 || ((pa_s20 >> sh12_s20) != '0));
	assign sat6_c  = (pb_s20 >> sh6_s20) != '0;

	assign diff_c = $signed({1'b0, t12_s21}) - $signed({1'b0, t6_s21});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s19 <= '0;
			ctl_s20 <= '0;
			ctl_s21 <= '0;
			ctl_s22 <= '0;
			vld_s23 <= 1'b0;
		end else if (en) begin
			ctl_s19 <= ctl_i;
			ctl_s20 <= ctl_s19;
			ctl_s21 <= ctl_s20;
			ctl_s22 <= ctl_s21;
			vld_s23 <= ctl_s22.vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ahh_s19 <= coef_a[COEF_W-1:HALF_W] * u_i[COEF_W-1:HALF_W];
			ahl_s19 <= coef_a[COEF_W-1:HALF_W] * u_i[HALF_W-1:0];
			alh_s19 <= coef_a[HALF_W-1:0] * u_i[COEF_W-1:HALF_W];
			all_s19 <= coef_a[HALF_W-1:0] * u_i[HALF_W-1:0];
			bhh_s19 <= coef_b[COEF_W-1:HALF_W] * s_i[COEF_W-1:HALF_W];
			bhl_s19 <= coef_b[COEF_W-1:HALF_W] * s_i[HALF_W-1:0];
			blh_s19 <= coef_b[HALF_W-1:0] * s_i[COEF_W-1:HALF_W];
			bll_s19 <= coef_b[HALF_W-1:0] * s_i[HALF_W-1:0];
			p_s19   <= p_i;

			pa_s20     <= join_prod(ahh_s19, ahl_s19, alh_s19, all_s19);
			pb_s20     <= join_prod(bhh_s19, bhl_s19, blh_s19, bll_s19);
			k12pos_s20 <= p6_c < SH_W'(128);
			l12_s20    <= SH_W'(128) - p6_c;
			r12_s20    <= p6_c - SH_W'(128);
			sh12_s20   <= p6_c - SH_W'(2);
			p0_s20     <= p_s19 == '0;
			k6pos_s20  <= p3_c < SH_W'(64);
			l6_s20     <= SH_W'(64) - p3_c;
			r6_s20     <= p3_c - SH_W'(64);
			sh6_s20    <= p3_c + SH_W'(62);

			t12_s21 <= sat12_c ? TERM_CAP : v12_c[TERM_W-1:0];
			t6_s21  <= sat6_c ? TERM_CAP : v6_c[TERM_W-1:0];
			sat_s21 <= sat12_c | sat6_c;

			diff_s22 <= diff_c;
			sat_s22  <= sat_s21;

			if (ctl_s22.coinc) begin
				energy_s23 <= ENERGY_MAX;
				status_s23 <= STAT_COINC;
			end else if (diff_s22 > $signed({{(TERM_W+1-E_W){1'b0}}, ENERGY_MAX})) begin
				energy_s23 <= ENERGY_MAX;
				status_s23 <= STAT_SAT;
			end else if (diff_s22 < $signed({{(TERM_W+1-E_W){1'b1}}, ENERGY_MIN})) begin
				energy_s23 <= ENERGY_MIN;
				status_s23 <= STAT_SAT;
			end else begin
				energy_s23 <= diff_s22[E_W-1:0];
				status_s23 <= sat_s22 ? STAT_SAT : STAT_OK;
			end
		end
	end

	assign vld_o    = vld_s23;
	assign energy_o = energy_s23;
	assign status_o = status_s23;

endmodule

`default_nettype wire

### design/lje_checker.sv
// ----------------------------------------------------------------------------
// lje_checker
// Port-level checks of the pair energy core, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module lje_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [63:0] pair_energy,
	input logic [1:0]  status
);
	import lje_pkg::*;

	`LJE_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(pair_energy) && $stable(status), "stalled result changed")
	`LJE_ASSERT_IMPL(a_stall_blocks_input, out_valid && !out_ready, !in_ready, "request taken while result stalled")
	`LJE_ASSERT_IMPL(a_status_code, out_valid, status == STAT_OK || status == STAT_SAT || status == STAT_COINC, "unknown status code")
	`LJE_ASSERT_IMPL(a_coinc_max, out_valid && status == STAT_COINC, pair_energy == ENERGY_MAX, "coincident atoms without maximum energy")

endmodule

bind lennard_jones_energy_ab_core lje_checker u_lje_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_ch.valid),
	.in_ready    (in_ch.ready),
	.out_valid   (out_ch.valid),
	.out_ready   (out_ch.ready),
	.pair_energy (out_ch.pair_energy),
	.status      (out_ch.status)
);

`default_nettype wire
